### rtl/crcfca_pkg.sv
// ----------------------------------------------------------------------------
// crcfca_pkg
// shared types, codes and the byte-wise reflected crc update
// ----------------------------------------------------------------------------
`default_nettype none

package crcfca_pkg;

  localparam int CRC_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int CFG_IW  = 2;
  localparam int QDEPTH  = 4;
  localparam int QAW     = $clog2(QDEPTH);

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_MODE_APPEND = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_CRC_INIT    = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_CRC_POLY    = 2'd2;

  localparam logic [CRC_W-1:0] CRC_INIT_RST = 16'hffff;
  localparam logic [CRC_W-1:0] CRC_POLY_RST = 16'h8408;

  // kinds of queued work
  localparam logic [1:0] KIND_ECHO   = 2'd0;  // one echoed byte
  localparam logic [1:0] KIND_APPEND = 2'd1;  // echo then crc low, crc high
  localparam logic [1:0] KIND_VERIFY = 2'd2;  // verify verdict at frame end

  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] data;
    logic              ok;
    logic [CRC_W-1:0]  crc;
  } q_entry_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0]  crc,
                                                input logic [BYTE_W-1:0] b,
                                                input logic [CRC_W-1:0]  poly);
    logic [CRC_W-1:0] c;
    c = {{(CRC_W-BYTE_W){1'b0}}, crc[BYTE_W-1:0] ^ b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ poly;
      end else begin
        c = c >> 1;
      end
    end
    return (crc >> BYTE_W) ^ c;
  endfunction

endpackage

`default_nettype wire

### rtl/crcfca_front.sv
// ----------------------------------------------------------------------------
// crcfca_front
// configuration registers, crc state and trailer hold; classifies each byte
// ----------------------------------------------------------------------------
`default_nettype none

module crcfca_front import crcfca_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CRC_W-1:0]  cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] in_data_byte,
  input  wire logic              in_last_byte,
  input  wire logic              q_full,
  output logic                   q_push,
  output q_entry_t               q_wdata
);

  logic              mode_r, mode_nxt;
  logic [CRC_W-1:0]  init_r, init_nxt;
  logic [CRC_W-1:0]  poly_r, poly_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [BYTE_W-1:0] h0_r, h0_nxt, h1_r, h1_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [CRC_W-1:0]  crc_upd;
  logic [BYTE_W-1:0] crc_src;
  logic [1:0]        cnt_upd;
  logic              accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // append mode feeds the new byte, verify mode the oldest held byte
  assign crc_src = mode_r ? in_data_byte : h0_r;

  always_comb begin
    mode_nxt = mode_r;
    init_nxt = init_r;
    poly_nxt = poly_r;
    crc_nxt  = crc_r;
    h0_nxt   = h0_r;
    h1_nxt   = h1_r;
    cnt_nxt  = cnt_r;
    q_push   = 1'b0;
    q_wdata  = '0;
    crc_upd  = crc_r;
    cnt_upd  = cnt_r;

    if (mode_r || cnt_r >= 2'd2) begin
      crc_upd = crc_byte(crc_r, crc_src, poly_r);
    end
    if (cnt_r >= 2'd2) begin
      cnt_upd = 2'd3;
    end else begin
      cnt_upd = cnt_r + 2'd1;
    end

    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MODE_APPEND: mode_nxt = cfg_wdata[0];
        CFG_CRC_INIT:    init_nxt = cfg_wdata;
        CFG_CRC_POLY:    poly_nxt = cfg_wdata;
        default: ;
      endcase
      if (cfg_index == CFG_MODE_APPEND || cfg_index == CFG_CRC_INIT ||
          cfg_index == CFG_CRC_POLY) begin
        crc_nxt = init_nxt;
        h0_nxt  = '0;
        h1_nxt  = '0;
        cnt_nxt = '0;
      end
    end else if (accept) begin
      if (mode_r) begin
        q_push       = 1'b1;
        q_wdata.kind = in_last_byte ? KIND_APPEND : KIND_ECHO;
        q_wdata.data = in_data_byte;
        q_wdata.crc  = crc_upd;
        crc_nxt      = in_last_byte ? init_r : crc_upd;
      end else begin
        if (in_last_byte) begin
          q_push       = 1'b1;
          q_wdata.kind = KIND_VERIFY;
          q_wdata.crc  = crc_upd;
          q_wdata.ok   = (cnt_upd == 2'd3) && (h1_r == crc_upd[7:0]) &&
                         (in_data_byte == crc_upd[15:8]);
          crc_nxt      = init_r;
          h0_nxt       = '0;
          h1_nxt       = '0;
          cnt_nxt      = '0;
        end else begin
          crc_nxt = crc_upd;
          h0_nxt  = h1_r;
          h1_nxt  = in_data_byte;
          cnt_nxt = cnt_upd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      init_r <= CRC_INIT_RST;
      poly_r <= CRC_POLY_RST;
      crc_r  <= CRC_INIT_RST;
      h0_r   <= '0;
      h1_r   <= '0;
      cnt_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      init_r <= init_nxt;
      poly_r <= poly_nxt;
      crc_r  <= crc_nxt;
      h0_r   <= h0_nxt;
      h1_r   <= h1_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/crcfca_queue.sv
// ----------------------------------------------------------------------------
// crcfca_queue
// short fifo of classified work between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module crcfca_queue import crcfca_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t wdata,
  input  wire logic     pop,
  output q_entry_t      rdata,
  output logic          full,
  output logic          empty
);

  q_entry_t         mem [QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + QAW'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + QAW'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (QAW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/crcfca_back.sv
// ----------------------------------------------------------------------------
// crcfca_back
// expands queued work into requests on the output register
// ----------------------------------------------------------------------------
`default_nettype none

module crcfca_back import crcfca_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire q_entry_t          q_rdata,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_is_check_byte,
  output logic                   out_frame_end,
  output logic                   out_check_ok,
  output logic [CRC_W-1:0]       out_crc_value
);

  logic              valid_r, valid_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              chk_r, chk_nxt;
  logic              end_r, end_nxt;
  logic              ok_r, ok_nxt;
  logic [CRC_W-1:0]  crc_r;
  logic              load, last_phase;

  assign load       = !q_empty && (!valid_r || !out_stall);
  assign last_phase = (q_rdata.kind != KIND_APPEND) || (phase_r == 2'd2);
  assign q_pop      = load && last_phase;

  always_comb begin
    byte_nxt = '0;
    chk_nxt  = 1'b0;
    end_nxt  = 1'b0;
    ok_nxt   = 1'b0;
    unique case (q_rdata.kind)
      KIND_ECHO: byte_nxt = q_rdata.data;
      KIND_APPEND: begin
        unique case (phase_r)
          2'd0: byte_nxt = q_rdata.data;
          2'd1: begin
            byte_nxt = q_rdata.crc[7:0];
            chk_nxt  = 1'b1;
          end
          default: begin
            byte_nxt = q_rdata.crc[15:8];
            chk_nxt  = 1'b1;
            end_nxt  = 1'b1;
          end
        endcase
      end
      KIND_VERIFY: begin
        end_nxt = 1'b1;
        ok_nxt  = q_rdata.ok;
      end
      default: ;
    endcase

    if (q_pop) begin
      phase_nxt = '0;
    end else if (load) begin
      phase_nxt = phase_r + 2'd1;
    end else begin
      phase_nxt = phase_r;
    end

    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_stall) begin
      valid_nxt = valid_r;
    end else begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      chk_r  <= chk_nxt;
      end_r  <= end_nxt;
      ok_r   <= ok_nxt;
      crc_r  <= q_rdata.crc;
    end
  end

  assign out_valid         = valid_r;
  assign out_byte          = byte_r;
  assign out_is_check_byte = chk_r;
  assign out_frame_end     = end_r;
  assign out_check_ok      = ok_r;
  assign out_crc_value     = crc_r;

  // a partly expanded entry must be an append entry still at the queue head
  a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd0 |-> !q_empty && q_rdata.kind == KIND_APPEND)
    else $error("phase advanced without an append entry at head");

  // final phase of an append entry yields the closing check byte
  a_append_close: assert property (@(posedge clk) disable iff (!rst_n)
    load && q_rdata.kind == KIND_APPEND && phase_r == 2'd2
    |=> valid_r && chk_r && end_r)
    else $error("append entry did not close with high crc byte");

  // a check byte never carries a verify verdict
  a_chk_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && chk_r |-> !ok_r)
    else $error("check byte flagged as verify pass");

endmodule

`default_nettype wire

### rtl/crc16_frame_check_append.sv
// ----------------------------------------------------------------------------
// crc16_frame_check_append
// streaming reflected crc-16 over byte frames, trailer check or crc append
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle on the in_ channel and runs a
// reflected byte-wise crc-16 (0x8408, init 0xffff by default, no final xor).
// In verify mode the last two bytes of each frame are held back as the
// trailer and a single request with frame_end and check_ok comes out at the
// last byte. In append mode each byte is echoed with the running crc and the
// last byte is followed by the crc low and high bytes. A new byte is taken
// every cycle as long as the four-entry work queue has room; the output side
// drains one request per cycle unless stalled, so the only slow case is the
// last byte of an append-mode frame, which expands into three requests. Bytes
// reach the output register through the queue. Configuration writes restart
// the current frame and are meant to happen only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_frame_check_append import crcfca_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration write port
  input  wire logic              cfg_wr_en,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CRC_W-1:0]  cfg_wdata,
  // byte input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] in_data_byte,
  input  wire logic              in_last_byte,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_is_check_byte,
  output logic                   out_frame_end,
  output logic                   out_check_ok,
  output logic [CRC_W-1:0]       out_crc_value
);

  // classified work passes from front to back through this queue
  q_entry_t q_wdata, q_rdata;
  logic     q_push, q_pop, q_full, q_empty;

  // front: config registers, crc update, trailer hold, classification
  crcfca_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  // queue decouples the input handshake from output back-pressure
  crcfca_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: expands each entry into one or three requests
  crcfca_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_rdata           (q_rdata),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_is_check_byte (out_is_check_byte),
    .out_frame_end     (out_frame_end),
    .out_check_ok      (out_check_ok),
    .out_crc_value     (out_crc_value)
  );

endmodule

`default_nettype wire
